// File: sv/mkd_pkg.sv
// Shared types, constants and Morse tree tables for the Morse key decoder.
`default_nettype none

package mkd_pkg;

  localparam int CFG_W           = 16;
  localparam int CHAR_W          = 7;
  localparam int NODE_W          = 6;
  localparam int NODE_COUNT      = 45;
  localparam int CFG_IDX_W       = 2;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic [NODE_W-1:0] NODE_ROOT = NODE_W'(0);
  localparam logic [NODE_W-1:0] NODE_ERR  = NODE_W'(44);

  localparam logic [CFG_W-1:0] DASH_THRESHOLD_RST = CFG_W'(115);
  localparam logic [CFG_W-1:0] CHAR_GAP_RST       = CFG_W'(300);
  localparam logic [CFG_W-1:0] WORD_GAP_RST       = CFG_W'(700);

  localparam logic [CHAR_W-1:0] CHAR_SPACE   = CHAR_W'(32);
  localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = CHAR_W'(63);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DASH_THRESHOLD = 2'd0,
    REG_CHAR_GAP       = 2'd1,
    REG_WORD_GAP       = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] dash_threshold;
    logic [CFG_W-1:0] char_gap_ticks;
    logic [CFG_W-1:0] word_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic              emit;
    logic [CHAR_W-1:0] code;
  } step_res_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              key_prev;
    logic              gap_running;
  } core_status_t;

  localparam logic [NODE_W-1:0] TREE_DIT [NODE_COUNT] = '{
    6'd1,  6'd3,  6'd5,  6'd7,  6'd9,  6'd11, 6'd13, 6'd15, 6'd17, 6'd19,
    6'd21, 6'd23, 6'd25, 6'd27, 6'd29, 6'd31, 6'd44, 6'd44, 6'd44, 6'd44,
    6'd35, 6'd44, 6'd44, 6'd37, 6'd39, 6'd44, 6'd44, 6'd40, 6'd44, 6'd41,
    6'd42, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44,
    6'd44, 6'd44, 6'd44, 6'd44, 6'd44
  };

  localparam logic [NODE_W-1:0] TREE_DASH [NODE_COUNT] = '{
    6'd2,  6'd4,  6'd6,  6'd8,  6'd10, 6'd12, 6'd14, 6'd16, 6'd18, 6'd20,
    6'd22, 6'd24, 6'd26, 6'd28, 6'd30, 6'd32, 6'd33, 6'd44, 6'd34, 6'd44,
    6'd44, 6'd44, 6'd36, 6'd38, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44,
    6'd43, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44,
    6'd44, 6'd44, 6'd44, 6'd44, 6'd44
  };

  localparam logic [7:0] NODE_ASCII [NODE_COUNT] = '{
    "?", "E", "T", "I", "A", "N", "M", "S", "U", "R",
    "W", "D", "K", "G", "O", "H", "V", "F", "?", "L",
    "?", "P", "J", "B", "X", "C", "Y", "Z", "Q", "?",
    "?", "5", "4", "3", "2", "+", "1", "6", "=", "/",
    "7", "8", "9", "0", "?"
  };

  function automatic logic [NODE_W-1:0] node_index(input logic [NODE_W-1:0] node);
    return (node < NODE_W'(NODE_COUNT)) ? node : NODE_ERR;
  endfunction

  function automatic logic [NODE_W-1:0] tree_step(input logic [NODE_W-1:0] node,
                                                   input logic            dash);
    logic [NODE_W-1:0] idx;
    idx = node_index(node);
    return dash ? TREE_DASH[idx] : TREE_DIT[idx];
  endfunction

  function automatic logic [CHAR_W-1:0] node_code(input logic [NODE_W-1:0] node);
    logic [7:0] ascii;
    ascii = NODE_ASCII[node_index(node)];
    return ascii[CHAR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/mkd_if.sv
// Handshake channel interfaces for key samples, decoded characters and register writes.
`default_nettype none

interface mkd_key_if
  import mkd_pkg::*;
();
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink   (input valid, input key_level, output ready);
endinterface

interface mkd_char_if
  import mkd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface mkd_cfg_if
  import mkd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/morse_key_decoder.sv
// Morse key decoder top level: input register, decode core, result register, registers.
// Samples pass the input register and core; characters are registered for out_beat.
// One key sample per cycle unless stalled; the result register decouples a stalled output.
// The input register stalls only while it and the result register are full and out is held.
// Reset (rst_n low, synchronous) returns the tree to the root, clears counters and
// loads the register defaults: dash 115, character gap 300, word gap 700 ticks.
`default_nettype none

module morse_key_decoder
  import mkd_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  mkd_key_if.sink   in_beat,
  mkd_char_if.source out_beat,
  mkd_cfg_if.sink   cfg_beat
);

  cfg_t              cfg_r, cfg_nxt;
  logic              stg_valid_r, stg_valid_nxt;
  logic              stg_key_r, stg_key_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;

  logic         advance;
  logic         step_en;
  logic         in_take;
  step_res_t    res;
  core_status_t status;

  assign advance        = !out_valid_r || out_beat.ready;
  assign step_en        = stg_valid_r && advance;
  assign in_beat.ready  = !stg_valid_r || advance;
  assign in_take        = in_beat.valid && in_beat.ready;
  assign cfg_beat.ready = 1'b1;

  mkd_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .key     (stg_key_r),
    .cfg     (cfg_r),
    .res     (res),
    .status  (status)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_beat.valid) begin
      unique case (cfg_reg_t'(cfg_beat.index))
        REG_DASH_THRESHOLD: cfg_nxt.dash_threshold = cfg_beat.data;
        REG_CHAR_GAP:       cfg_nxt.char_gap_ticks = cfg_beat.data;
        REG_WORD_GAP:       cfg_nxt.word_gap_ticks = cfg_beat.data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    stg_key_nxt   = stg_key_r;
    if (in_take) begin
      stg_valid_nxt = 1'b1;
      stg_key_nxt   = in_beat.key_level;
    end else if (advance) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    if (advance) begin
      out_valid_nxt = step_en && res.emit;
      if (step_en && res.emit) begin
        out_char_nxt = res.code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dash_threshold <= DASH_THRESHOLD_RST;
      cfg_r.char_gap_ticks <= CHAR_GAP_RST;
      cfg_r.word_gap_ticks <= WORD_GAP_RST;
      stg_valid_r          <= 1'b0;
      out_valid_r          <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stg_key_r  <= stg_key_nxt;
    out_char_r <= out_char_nxt;
  end

  assign out_beat.valid     = out_valid_r;
  assign out_beat.char_code = out_char_r;

  a_node_range: assert property (@(posedge clk) disable iff (!rst_n)
    status.node <= NODE_ERR)
    else $error("tree node outside the Morse tree");

  a_emit_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.emit |-> !stg_key_r && !status.key_prev && status.gap_running)
    else $error("character emitted outside an idle gap");

  a_space_to_root: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.emit && res.code == CHAR_SPACE
      |=> status.node == NODE_ROOT && !status.gap_running && out_valid_r
          && out_char_r == CHAR_SPACE)
    else $error("word space did not return to root and stop the gap");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_beat.ready |-> stg_valid_r && out_valid_r && !out_beat.ready)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// File: sv/mkd_core.sv
// Press and gap timing, Morse tree walk and character emission for one key sample per step.
`default_nettype none

module mkd_core
  import mkd_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step_en,
  input  wire logic         key,
  input  wire cfg_t         cfg,
  output      step_res_t    res,
  output      core_status_t status
);

  localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [NODE_W-1:0]      tree_node_r,   tree_node_nxt;
  logic                   key_prev_r,    key_prev_nxt;
  logic [COUNT_WIDTH-1:0] press_count_r, press_count_nxt;
  logic [COUNT_WIDTH-1:0] gap_count_r,   gap_count_nxt;
  logic                   gap_running_r, gap_running_nxt;

  logic [COUNT_WIDTH-1:0] gap_inc;
  logic                   is_dash;
  logic                   word_hit;
  logic                   char_hit;

  always_comb begin
    gap_inc  = (gap_count_r == CNT_MAX) ? gap_count_r : gap_count_r + COUNT_WIDTH'(1);
    is_dash  = !(CMP_W'(press_count_r) < CMP_W'(cfg.dash_threshold));
    word_hit = (CMP_W'(gap_inc) == CMP_W'(cfg.word_gap_ticks));
    char_hit = (CMP_W'(gap_inc) == CMP_W'(cfg.char_gap_ticks));
  end

  always_comb begin
    tree_node_nxt   = tree_node_r;
    key_prev_nxt    = key_prev_r;
    press_count_nxt = press_count_r;
    gap_count_nxt   = gap_count_r;
    gap_running_nxt = gap_running_r;
    res.emit        = 1'b0;
    res.code        = CHAR_SPACE;
    if (step_en) begin
      key_prev_nxt = key;
      priority if (key && !key_prev_r) begin
        gap_running_nxt = 1'b0;
        gap_count_nxt   = '0;
        press_count_nxt = COUNT_WIDTH'(1);
      end else if (key) begin
        if (press_count_r != CNT_MAX) begin
          press_count_nxt = press_count_r + COUNT_WIDTH'(1);
        end
      end else if (key_prev_r) begin
        tree_node_nxt   = tree_step(tree_node_r, is_dash);
        press_count_nxt = '0;
        gap_count_nxt   = '0;
        gap_running_nxt = 1'b1;
      end else if (gap_running_r) begin
        gap_count_nxt = gap_inc;
        priority if (word_hit) begin
          res.emit        = 1'b1;
          res.code        = CHAR_SPACE;
          tree_node_nxt   = NODE_ROOT;
          gap_running_nxt = 1'b0;
          gap_count_nxt   = '0;
        end else if (char_hit) begin
          res.emit      = 1'b1;
          res.code      = node_code(tree_node_r);
          tree_node_nxt = NODE_ROOT;
        end else begin
          res.emit = 1'b0;
        end
      end else begin
        res.emit = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_node_r   <= NODE_ROOT;
      key_prev_r    <= 1'b0;
      press_count_r <= '0;
      gap_count_r   <= '0;
      gap_running_r <= 1'b0;
    end else begin
      tree_node_r   <= tree_node_nxt;
      key_prev_r    <= key_prev_nxt;
      press_count_r <= press_count_nxt;
      gap_count_r   <= gap_count_nxt;
      gap_running_r <= gap_running_nxt;
    end
  end

  assign status.node        = tree_node_r;
  assign status.key_prev    = key_prev_r;
  assign status.gap_running = gap_running_r;

endmodule

`default_nettype wire
